// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator: shared definitions
// Mark and status codes, register indexes, controller command and datapath
// status types.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int ADDR_BITS      = 32;
  localparam int WIDE_W         = 36;
  localparam int FB_W           = 23;

  localparam logic [31:0] GRANT_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [31:0]     BASE_RST = 32'd0;
  localparam logic [16:0]     BS_RST   = 17'd64;
  localparam logic [16:0]     BS_MAX   = 17'd65536;
  localparam logic [FB_W-1:0] FB_MAX   = {FB_W{1'b1}};

  typedef enum logic [1:0] {
    CFG_BASE   = 2'd0,
    CFG_BSIZE  = 2'd1,
    CFG_BCOUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MARK_FREE  = 2'd0,
    MARK_START = 2'd1,
    MARK_CONT  = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_ZERO_SIZE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_READ,
    OP_FF_CHECK,
    OP_MARK,
    OP_DIV_STEP,
    OP_AL_INIT,
    OP_AL_SKIP,
    OP_AL_CAND,
    OP_AL_LAST,
    OP_AL_NEXT,
    OP_AL_HIT,
    OP_FR_STEP,
    OP_FR_CLEAR,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_mode;
    logic in_req_zero;
    logic in_align_zero;
    logic clr_last;
    logic div_done;
    logic ff_hit;
    logic j_end;
    logic al_end;
    logic al_skip;
    logic al_over;
    logic rd_free;
    logic rd_start;
    logic rd_cont;
    logic j_last_blk;
    logic mark_done;
    logic fr_range_bad;
    logic fr_found;
    logic out_ready;
  } dp_sts_t;

endpackage

// ===== hw/rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First fit and aligned allocation over a map of equal blocks, with run
// release and a free byte count on every result.
// ----------------------------------------------------------------------------
// One item is worked on at a time, around the single-port mark memory. After
// reset and after each write to a known register the whole map is cleared,
// during which no beat is taken. First fit reads and checks each block in
// turn and then marks the run that it found; an aligned request first runs
// two remainder calculations, then steps over candidate blocks and checks
// the blocks of each candidate; a free steps block by block up to the named
// block and then releases the run block by block. The result is then handed
// to the output register, and the next beat is taken while that result waits.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] request_bytes_i,
  input  logic [16:0] align_bytes_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] grant_address_o,
  output logic [1:0]  status_o,
  output logic [22:0] free_bytes_o
);

  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .request_bytes_i (request_bytes_i),
    .align_bytes_i   (align_bytes_i),
    .free_address_i  (free_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .grant_address_o (grant_address_o),
    .status_o        (status_o),
    .free_bytes_o    (free_bytes_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  a_mark_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_MARK |-> !sts.j_end)
    else $error("run marking beyond the blocks in use");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_RESULT |-> sts.out_ready)
    else $error("result loaded over an untaken beat");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_BASE || cfg_idx_i == CFG_BSIZE ||
                 cfg_idx_i == CFG_BCOUNT) |=> in_stall_o)
    else $error("beat taken during map clearing");

endmodule

// ===== hw/rtl/bba_rem.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator: remainder unit
// Restoring remainder of a 32-bit dividend by a 17-bit divisor, one bit per
// cycle; done pulses once when the remainder is ready.
// ----------------------------------------------------------------------------
module bba_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        done_o,
  output logic [16:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] a_q, a_d;
  logic [16:0] d_q, d_d;
  logic [16:0] rem_q, rem_d;
  logic [17:0] trial;
  logic [17:0] diff;

  assign trial = {rem_q, a_q[31]};
  assign diff  = trial - {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    d_d    = d_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = dividend_i;
      d_d    = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, d_q}) ? diff[16:0] : trial[16:0];
      a_d   = {a_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator: datapath
// Configuration registers, block mark memory, scan counters and address
// accumulators, remainder unit and the result register.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             mode_i,
  input  logic [31:0]      request_bytes_i,
  input  logic [16:0]      align_bytes_i,
  input  logic [31:0]      free_address_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      grant_address_o,
  output logic [1:0]       status_o,
  output logic [22:0]      free_bytes_o,
  input  bba_pkg::dp_cmd_t cmd_i,
  output bba_pkg::dp_sts_t sts_o
);

  import bba_pkg::*;

  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int BC_RST = (NUM_BLOCKS < 64) ? NUM_BLOCKS : 64;
  localparam int PW     = 17 + CNT_W;

  logic [31:0]       base_q, base_d;
  logic [16:0]       bs_q, bs_d;
  logic [CNT_W-1:0]  bc_q, bc_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [WIDE_W-1:0] end_q, end_d;

  logic [31:0]       req_q, req_d;
  logic [16:0]       align_q, align_d;
  logic [31:0]       faddr_q, faddr_d;
  logic [31:0]       grant_q, grant_d;
  logic [1:0]        status_q, status_d;

  logic [CNT_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  b_q, b_d;
  logic [CNT_W-1:0]  start_q, start_d;
  logic [CNT_W-1:0]  mk_end_q, mk_end_d;
  logic [WIDE_W-1:0] jlo_q, jlo_d;
  logic [WIDE_W-1:0] lo_q, lo_d;
  logic [WIDE_W-1:0] run_q, run_d;
  logic [WIDE_W-1:0] start_lo_q, start_lo_d;
  logic [WIDE_W-1:0] cand_q, cand_d;
  logic [WIDE_W-1:0] last_q, last_d;
  logic [16:0]       r_q, r_d;
  logic [16:0]       step_q, step_d;

  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_grant_q, out_grant_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [FB_W-1:0]   out_fb_q, out_fb_d;

  logic [1:0]        marks_q [NUM_BLOCKS];
  logic [1:0]        rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [1:0]        mem_wdata;

  logic [16:0]       bs_cfg;
  logic [31:0]       bc_v;
  logic              cfg_hit;
  logic [WIDE_W-1:0] bs_w;
  logic [WIDE_W-1:0] run_new;
  logic [CNT_W-1:0]  start_eff;
  logic [WIDE_W-1:0] start_lo_eff;
  logic [16:0]       off;
  logic [17:0]       r_sum;
  logic [16:0]       r_next;
  logic [WIDE_W-1:0] last_calc;
  logic [PW-1:0]     end_prod;
  logic [PW-1:0]     fb_prod;
  logic [63:0]       fb_wide;
  logic [FB_W-1:0]   fb_sat;
  logic              div_start;
  logic [31:0]       div_dividend;
  logic [16:0]       div_divisor;
  logic              div_done;
  logic [16:0]       div_rem;

  bba_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign div_start = ((cmd_i.op == OP_ACCEPT) && !mode_i && (request_bytes_i != '0) &&
                      (align_bytes_i != '0)) || (cmd_i.op == OP_DIV_STEP);
  assign div_dividend = (cmd_i.op == OP_ACCEPT) ? base_q : {15'd0, bs_q};
  assign div_divisor  = (cmd_i.op == OP_ACCEPT) ? align_bytes_i : align_q;

  always_comb begin
    bs_cfg = cfg_data_i[16:0];
    if (bs_cfg == '0) bs_cfg = 17'd1;
    if (bs_cfg > BS_MAX) bs_cfg = BS_MAX;
    bc_v = {25'd0, cfg_data_i[6:0]};
    if (bc_v == '0) bc_v = 32'd1;
    if (bc_v > 32'(NUM_BLOCKS)) bc_v = 32'(NUM_BLOCKS);
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {CFG_BASE, CFG_BSIZE, CFG_BCOUNT});

  assign bs_w         = WIDE_W'(bs_q);
  assign run_new      = run_q + bs_w;
  assign start_eff    = (run_q == '0) ? j_q : start_q;
  assign start_lo_eff = (run_q == '0) ? jlo_q : start_lo_q;
  assign off          = (r_q == '0) ? '0 : align_q - r_q;
  assign r_sum        = {1'b0, r_q} + {1'b0, step_q};
  assign r_next       = (r_sum >= {1'b0, align_q}) ? 17'(r_sum - {1'b0, align_q}) : r_sum[16:0];
  assign last_calc    = cand_q + WIDE_W'(req_q) - WIDE_W'(1);
  assign end_prod     = PW'(bs_q) * PW'(bc_q);
  assign fb_prod      = PW'(bs_q) * PW'(free_q);
  assign fb_wide      = 64'(fb_prod);
  assign fb_sat       = (fb_wide > 64'(FB_MAX)) ? FB_MAX : fb_wide[FB_W-1:0];

  always_comb begin
    base_d       = base_q;
    bs_d         = bs_q;
    bc_d         = bc_q;
    free_d       = free_q;
    clr_d        = clr_q;
    end_d        = WIDE_W'(base_q) + WIDE_W'(end_prod);
    req_d        = req_q;
    align_d      = align_q;
    faddr_d      = faddr_q;
    grant_d      = grant_q;
    status_d     = status_q;
    j_d          = j_q;
    b_d          = b_q;
    start_d      = start_q;
    mk_end_d     = mk_end_q;
    jlo_d        = jlo_q;
    lo_d         = lo_q;
    run_d        = run_q;
    start_lo_d   = start_lo_q;
    cand_d       = cand_q;
    last_d       = last_q;
    r_d          = r_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_grant_d  = out_grant_q;
    out_status_d = out_status_q;
    out_fb_d     = out_fb_q;
    mem_we       = 1'b0;
    mem_addr     = j_q[IDX_W-1:0];
    mem_wdata    = MARK_FREE;

    case (cmd_i.op)
      OP_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + IDX_W'(1);
        free_d   = bc_q;
      end
      OP_ACCEPT: begin
        req_d    = request_bytes_i;
        align_d  = align_bytes_i;
        faddr_d  = free_address_i;
        grant_d  = '0;
        if (mode_i) status_d = ST_BAD_FREE;
        else if (request_bytes_i == '0) status_d = ST_ZERO_SIZE;
        else status_d = ST_NO_SPACE;
        j_d      = '0;
        jlo_d    = WIDE_W'(base_q);
        run_d    = '0;
      end
      OP_FF_CHECK: begin
        if (rd_q == MARK_FREE) begin
          if (run_new >= WIDE_W'(req_q)) begin
            mk_end_d = j_q;
            j_d      = start_eff;
            start_d  = start_eff;
            grant_d  = start_lo_eff[31:0] & GRANT_MASK;
            status_d = ST_OK;
          end else begin
            run_d      = run_new;
            start_d    = start_eff;
            start_lo_d = start_lo_eff;
            j_d        = j_q + CNT_W'(1);
            jlo_d      = jlo_q + bs_w;
          end
        end else begin
          run_d = '0;
          j_d   = j_q + CNT_W'(1);
          jlo_d = jlo_q + bs_w;
        end
      end
      OP_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = (j_q == start_q) ? MARK_START : MARK_CONT;
        free_d    = free_q - CNT_W'(1);
        j_d       = j_q + CNT_W'(1);
      end
      OP_DIV_STEP: r_d = div_rem;
      OP_AL_INIT: begin
        step_d = div_rem;
        b_d    = '0;
        lo_d   = WIDE_W'(base_q);
      end
      OP_AL_SKIP: begin
        b_d  = b_q + CNT_W'(1);
        lo_d = lo_q + bs_w;
        r_d  = r_next;
      end
      OP_AL_CAND: cand_d = lo_q + WIDE_W'(off);
      OP_AL_LAST: begin
        last_d = last_calc;
        j_d    = b_q;
        jlo_d  = lo_q;
      end
      OP_AL_NEXT, OP_FR_STEP: begin
        j_d   = j_q + CNT_W'(1);
        jlo_d = jlo_q + bs_w;
      end
      OP_AL_HIT: begin
        start_d  = b_q;
        mk_end_d = j_q;
        j_d      = b_q;
        grant_d  = cand_q[31:0] & GRANT_MASK;
        status_d = ST_OK;
      end
      OP_FR_CLEAR: begin
        mem_we   = 1'b1;
        free_d   = free_q + CNT_W'(1);
        j_d      = j_q + CNT_W'(1);
        status_d = ST_OK;
      end
      OP_RESULT: begin
        out_valid_d  = 1'b1;
        out_grant_d  = grant_q;
        out_status_d = status_q;
        out_fb_d     = fb_sat;
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:   base_d = cfg_data_i;
        CFG_BSIZE:  bs_d   = bs_cfg;
        CFG_BCOUNT: bc_d   = bc_v[CNT_W-1:0];
        default: ;
      endcase
    end
    if (cfg_hit) clr_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_RST;
      bs_q        <= BS_RST;
      bc_q        <= CNT_W'(BC_RST);
      free_q      <= CNT_W'(BC_RST);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      bs_q        <= bs_d;
      bc_q        <= bc_d;
      free_q      <= free_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q        <= end_d;
    req_q        <= req_d;
    align_q      <= align_d;
    faddr_q      <= faddr_d;
    grant_q      <= grant_d;
    status_q     <= status_d;
    j_q          <= j_d;
    b_q          <= b_d;
    start_q      <= start_d;
    mk_end_q     <= mk_end_d;
    jlo_q        <= jlo_d;
    lo_q         <= lo_d;
    run_q        <= run_d;
    start_lo_q   <= start_lo_d;
    cand_q       <= cand_d;
    last_q       <= last_d;
    r_q          <= r_d;
    step_q       <= step_d;
    out_grant_q  <= out_grant_d;
    out_status_q <= out_status_d;
    out_fb_q     <= out_fb_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) marks_q[mem_addr] <= mem_wdata;
    if (cmd_i.op == OP_READ) rd_q <= marks_q[j_q[IDX_W-1:0]];
  end

  always_comb begin
    sts_o.in_mode       = mode_i;
    sts_o.in_req_zero   = (request_bytes_i == '0);
    sts_o.in_align_zero = (align_bytes_i == '0);
    sts_o.clr_last      = (clr_q == IDX_W'(NUM_BLOCKS - 1));
    sts_o.div_done      = div_done;
    sts_o.ff_hit        = (run_new >= WIDE_W'(req_q));
    sts_o.j_end         = (j_q == bc_q);
    sts_o.al_end        = (b_q == bc_q);
    sts_o.al_skip       = (off >= bs_q);
    sts_o.al_over       = (last_calc >= end_q);
    sts_o.rd_free       = (rd_q == MARK_FREE);
    sts_o.rd_start      = (rd_q == MARK_START);
    sts_o.rd_cont       = (rd_q == MARK_CONT);
    sts_o.j_last_blk    = ((jlo_q + bs_w) > last_q);
    sts_o.mark_done     = (j_q == mk_end_q);
    sts_o.fr_range_bad  = (faddr_q < base_q) || (WIDE_W'(faddr_q) >= end_q);
    sts_o.fr_found      = ((jlo_q + bs_w) > WIDE_W'(faddr_q));
    sts_o.out_ready     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign grant_address_o = out_grant_q;
  assign status_o        = out_status_q;
  assign free_bytes_o    = out_fb_q;

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator: controller
// Sequences the clearing pass, the first fit and aligned searches, run
// marking, run release and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t cmd_o
);

  import bba_pkg::*;

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_FF_RD    = 16'h0004,
    S_FF_CHK   = 16'h0008,
    S_MARK     = 16'h0010,
    S_DIV_BASE = 16'h0020,
    S_DIV_STEP = 16'h0040,
    S_AL_CAND  = 16'h0080,
    S_AL_LAST  = 16'h0100,
    S_AL_RD    = 16'h0200,
    S_AL_CHK   = 16'h0400,
    S_FR_FIND  = 16'h0800,
    S_FR_CHK   = 16'h1000,
    S_FR_NEXT  = 16'h2000,
    S_FR_CCHK  = 16'h4000,
    S_RESULT   = 16'h8000
  } state_e;

  state_e state_q, state_d;
  dp_op_e op;
  logic   cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {CFG_BASE, CFG_BSIZE, CFG_BCOUNT});

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op = OP_ACCEPT;
          if (sts_i.in_mode) state_d = S_FR_FIND;
          else if (sts_i.in_req_zero) state_d = S_RESULT;
          else if (sts_i.in_align_zero) state_d = S_FF_RD;
          else state_d = S_DIV_BASE;
        end
      end
      S_FF_RD: begin
        if (sts_i.j_end) state_d = S_RESULT;
        else begin
          op      = OP_READ;
          state_d = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        op      = OP_FF_CHECK;
        state_d = (sts_i.rd_free && sts_i.ff_hit) ? S_MARK : S_FF_RD;
      end
      S_MARK: begin
        op = OP_MARK;
        if (sts_i.mark_done) state_d = S_RESULT;
      end
      S_DIV_BASE: begin
        if (sts_i.div_done) begin
          op      = OP_DIV_STEP;
          state_d = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        if (sts_i.div_done) begin
          op      = OP_AL_INIT;
          state_d = S_AL_CAND;
        end
      end
      S_AL_CAND: begin
        if (sts_i.al_end) state_d = S_RESULT;
        else if (sts_i.al_skip) op = OP_AL_SKIP;
        else begin
          op      = OP_AL_CAND;
          state_d = S_AL_LAST;
        end
      end
      S_AL_LAST: begin
        if (sts_i.al_over) state_d = S_RESULT;
        else begin
          op      = OP_AL_LAST;
          state_d = S_AL_RD;
        end
      end
      S_AL_RD: begin
        op      = OP_READ;
        state_d = S_AL_CHK;
      end
      S_AL_CHK: begin
        if (!sts_i.rd_free) begin
          op      = OP_AL_SKIP;
          state_d = S_AL_CAND;
        end else if (sts_i.j_last_blk) begin
          op      = OP_AL_HIT;
          state_d = S_MARK;
        end else begin
          op      = OP_AL_NEXT;
          state_d = S_AL_RD;
        end
      end
      S_FR_FIND: begin
        if (sts_i.fr_range_bad) state_d = S_RESULT;
        else if (sts_i.fr_found) begin
          op      = OP_READ;
          state_d = S_FR_CHK;
        end else op = OP_FR_STEP;
      end
      S_FR_CHK: begin
        if (sts_i.rd_start) begin
          op      = OP_FR_CLEAR;
          state_d = S_FR_NEXT;
        end else state_d = S_RESULT;
      end
      S_FR_NEXT: begin
        if (sts_i.j_end) state_d = S_RESULT;
        else begin
          op      = OP_READ;
          state_d = S_FR_CCHK;
        end
      end
      S_FR_CCHK: begin
        if (sts_i.rd_cont) begin
          op      = OP_FR_CLEAR;
          state_d = S_FR_NEXT;
        end else state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_ready) begin
          op      = OP_RESULT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_hit) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o.op   = op;

endmodule
